### hdl/lfu_pkg.sv
package lfu_pkg;

  // Build-time defaults
  localparam int ENTRIES_DEF     = 64;
  localparam int KEY_WIDTH_DEF   = 32;
  localparam int COUNT_WIDTH_DEF = 32;

  // Fixed field widths at the ports
  localparam int CAP_W   = 7;
  localparam int FIELD_W = 32;
  localparam int TDATA_IN_W  = FIELD_W;
  localparam int TDATA_OUT_W = 3 * FIELD_W;
  localparam int TUSER_OUT_W = 2;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

  // Controller -> datapath
  typedef struct packed {
    logic start;   // latch key, clear search trackers, rewind scan index
    logic issue;   // read entry at scan index, advance index
    logic commit;  // update entry, counters and output register
  } lfu_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic occ_zero;    // no resident entries
    logic last_issue;  // scan index is at the last resident entry
    logic out_free;    // output register can take a result this cycle
  } lfu_status_t;

endpackage

### hdl/lfu_ctrl.sv
module lfu_ctrl import lfu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  lfu_status_t status,
  output lfu_cmd_t    cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT
  } state_t;

  state_t state;

  assign in_ready   = (state == ST_IDLE);
  assign cmd.start  = (state == ST_IDLE) && in_valid;
  assign cmd.issue  = (state == ST_SCAN);
  assign cmd.commit = (state == ST_COMMIT) && status.out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= status.occ_zero ? ST_COMMIT : ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (status.last_issue) begin
            state <= ST_DRAIN;
          end
        end
        // last read word is compared in this cycle
        ST_DRAIN: begin
          state <= ST_COMMIT;
        end
        ST_COMMIT: begin
          if (status.out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### hdl/lfu_datapath.sv
module lfu_datapath import lfu_pkg::*; #(
  parameter int ENTRIES     = ENTRIES_DEF,
  parameter int KEY_WIDTH   = KEY_WIDTH_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  lfu_cmd_t               cmd,
  output lfu_status_t            status,
  input  logic [FIELD_W-1:0]     request_key,
  input  logic                   cfg_write,
  input  logic [CAP_W-1:0]       cfg_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   out_hit,
  output logic                   out_evicted,
  output logic [FIELD_W-1:0]     out_evicted_key,
  output logic [FIELD_W-1:0]     out_access_count,
  output logic [FIELD_W-1:0]     out_miss_total
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int OCC_W = $clog2(ENTRIES + 1);
  localparam int CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;

  logic [KEY_WIDTH-1:0]   key_mem [ENTRIES];
  logic [COUNT_WIDTH-1:0] cnt_mem [ENTRIES];

  logic [CAP_W-1:0]       capacity;
  logic [OCC_W-1:0]       occupancy;
  logic [FIELD_W-1:0]     misses;

  logic [KEY_WIDTH-1:0]   req_key;
  logic [IDX_W-1:0]       idx;

  // registered read stage
  logic                   rd_valid;
  logic [IDX_W-1:0]       rd_idx;
  logic [KEY_WIDTH-1:0]   rd_key;
  logic [COUNT_WIDTH-1:0] rd_cnt;

  // search trackers
  logic                   found;
  logic [IDX_W-1:0]       found_idx;
  logic [COUNT_WIDTH-1:0] found_cnt;
  logic                   have_min;
  logic [IDX_W-1:0]       min_idx;
  logic [COUNT_WIDTH-1:0] min_cnt;
  logic [KEY_WIDTH-1:0]   min_key;

  logic                   match;
  logic                   take_min;
  logic [CMP_W-1:0]       eff_cap;
  logic                   fill;
  logic                   evict;
  logic [IDX_W-1:0]       wr_idx;
  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic [FIELD_W-1:0]     misses_next;

  // capacity clamped to 1..ENTRIES
  always_comb begin
    if (capacity == '0) begin
      eff_cap = CMP_W'(1);
    end else if (CMP_W'(capacity) > CMP_W'(ENTRIES)) begin
      eff_cap = CMP_W'(ENTRIES);
    end else begin
      eff_cap = CMP_W'(capacity);
    end
  end

  assign fill    = !found && (CMP_W'(occupancy) < eff_cap);
  assign evict   = !found && !fill;
  assign wr_idx  = fill ? occupancy[IDX_W-1:0] : min_idx;
  assign cnt_inc = (found_cnt == '1) ? found_cnt : found_cnt + COUNT_WIDTH'(1);
  assign misses_next = (!found && misses != '1) ? misses + FIELD_W'(1) : misses;

  assign match    = (rd_key == req_key);
  assign take_min = !have_min || (rd_cnt < min_cnt) ||
                    ((rd_cnt == min_cnt) && (rd_key < min_key));

  assign status.occ_zero   = (occupancy == '0);
  assign status.last_issue = (OCC_W'(idx) == occupancy - OCC_W'(1));
  assign status.out_free   = !out_valid || out_ready;

  // key store: one read port for the scan, one write port for commit
  always_ff @(posedge clk) begin
    if (cmd.commit && !found) begin
      key_mem[wr_idx] <= req_key;
    end
    rd_key <= key_mem[idx];
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      cnt_mem[found ? found_idx : wr_idx] <= found ? cnt_inc : COUNT_WIDTH'(1);
    end
    rd_cnt <= cnt_mem[idx];
  end

  always_ff @(posedge clk) begin
    rd_idx <= idx;
    if (cmd.start) begin
      req_key <= KEY_WIDTH'(request_key);
    end
    if (cmd.start) begin
      idx <= '0;
    end else if (cmd.issue) begin
      idx <= idx + IDX_W'(1);
    end
    if (rd_valid && match && !found) begin
      found_idx <= rd_idx;
      found_cnt <= rd_cnt;
    end
    if (rd_valid && take_min) begin
      min_idx <= rd_idx;
      min_cnt <= rd_cnt;
      min_key <= rd_key;
    end
    if (cmd.commit) begin
      out_hit          <= found;
      out_evicted      <= evict;
      out_evicted_key  <= evict ? FIELD_W'(min_key) : '0;
      out_access_count <= found ? FIELD_W'(cnt_inc) : FIELD_W'(1);
      out_miss_total   <= misses_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity  <= CAP_RESET;
      occupancy <= '0;
      misses    <= '0;
      rd_valid  <= 1'b0;
      found     <= 1'b0;
      have_min  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_valid <= cmd.issue;
      if (cfg_write) begin
        capacity <= cfg_data;
      end
      if (cmd.start) begin
        found    <= 1'b0;
        have_min <= 1'b0;
      end else if (rd_valid) begin
        if (match) begin
          found <= 1'b1;
        end
        have_min <= 1'b1;
      end
      if (cmd.commit) begin
        misses <= misses_next;
        if (fill) begin
          occupancy <= occupancy + OCC_W'(1);
        end
      end
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### hdl/lfu_cache_replacement_core.sv
// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata: request_key
// m_axis    out  m_axis_tvalid/m_axis_tready  tuser: hit, evicted
//                                             tdata: evicted_key, access_count, miss_total
// cfg       in   cfg_valid/cfg_ready          cfg_data: capacity
//
// An item passes through taking the key, reading each resident entry through the single
// store port, comparing the last word read and committing once the result register is
// free; an empty store skips the reads and the compare. One item is in flight at a time.
// Entries fill the slots from 0 upwards and the occupancy count marks what is valid:
// reset clears the counters only, no sweep over the store.
// A held result stalls the commit, not the next key; cfg_ready is high, write when idle.
module lfu_cache_replacement_core import lfu_pkg::*; #(
  parameter int ENTRIES     = ENTRIES_DEF,
  parameter int KEY_WIDTH   = KEY_WIDTH_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [TDATA_IN_W-1:0]  s_axis_tdata,   // [31:0] request_key
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [TDATA_OUT_W-1:0] m_axis_tdata,   // [31:0] evicted_key, [63:32] access_count,
                                                 // [95:64] miss_total
  output logic [TUSER_OUT_W-1:0] m_axis_tuser,   // [0] hit, [1] evicted
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CAP_W-1:0]       cfg_data        // capacity
);

  lfu_cmd_t           cmd;
  lfu_status_t        status;
  logic               out_hit;
  logic               out_evicted;
  logic [FIELD_W-1:0] out_evicted_key;
  logic [FIELD_W-1:0] out_access_count;
  logic [FIELD_W-1:0] out_miss_total;

  assign cfg_ready = 1'b1;

  lfu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  lfu_datapath #(
    .ENTRIES     (ENTRIES),
    .KEY_WIDTH   (KEY_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .request_key      (s_axis_tdata[FIELD_W-1:0]),
    .cfg_write        (cfg_valid && cfg_ready),
    .cfg_data         (cfg_data),
    .out_valid        (m_axis_tvalid),
    .out_ready        (m_axis_tready),
    .out_hit          (out_hit),
    .out_evicted      (out_evicted),
    .out_evicted_key  (out_evicted_key),
    .out_access_count (out_access_count),
    .out_miss_total   (out_miss_total)
  );

  assign m_axis_tdata = {out_miss_total, out_access_count, out_evicted_key};
  assign m_axis_tuser = {out_evicted, out_hit};

endmodule

### dv/lfu_cache_replacement_core_test.sv
`timescale 1ns / 100ps

module lfu_cache_replacement_core_test;
  import lfu_pkg::*;

  localparam int KEY_POOL     = 80;
  localparam int PHASE_ITEMS  = 110;
  localparam int PHASES       = 12;
  // Settling time: the store depth plus a margin, beyond the slowest item.
  localparam int SETTLE_CYCLES = ENTRIES_DEF + 16;

  // One result transfer, as the block should present it.
  typedef struct packed {
    logic        hit;
    logic        evicted;
    logic [31:0] evicted_key;
    logic [31:0] access_count;
    logic [31:0] miss_total;
  } lfu_outcome_t;

  // Shadow copy of the LFU store. note_request() replays each accepted key and
  // queues the outcome; check_outcome() pops the oldest one and compares.
  class lfu_shadow;
    bit                         valid_q[ENTRIES_DEF];
    logic [31:0]                key_q[ENTRIES_DEF];
    logic [COUNT_WIDTH_DEF-1:0] count_q[ENTRIES_DEF];
    int unsigned                occupancy;
    logic [31:0]                misses;
    logic [CAP_W-1:0]           capacity;
    lfu_outcome_t               pending[$];
    int unsigned                mismatches;

    function new();
      foreach (valid_q[i]) valid_q[i] = 1'b0;
      occupancy  = 0;
      misses     = '0;
      capacity   = CAP_RESET;
      mismatches = 0;
    endfunction

    // Zero and oversize settings clamp to 1..ENTRIES.
    function int unsigned effective_capacity();
      if (capacity == 0) return 1;
      if (capacity > ENTRIES_DEF) return ENTRIES_DEF;
      return 32'(capacity);
    endfunction

    function void note_request(logic [31:0] key);
      int           found;
      int           slot;
      lfu_outcome_t o;
      found = -1;
      slot  = -1;
      o     = '0;
      for (int i = 0; i < ENTRIES_DEF; i++)
        if (found < 0 && valid_q[i] && key_q[i] == key) found = i;

      if (found >= 0) begin
        o.hit = 1'b1;
        if (count_q[found] != '1) count_q[found] = count_q[found] + 1'b1;
        o.access_count = count_q[found];
      end else begin
        if (misses != '1) misses = misses + 1'b1;
        if (occupancy < effective_capacity())
          for (int i = 0; i < ENTRIES_DEF; i++)
            if (slot < 0 && !valid_q[i]) slot = i;
        if (slot >= 0) begin
          occupancy++;
        end else begin
          // victim: lowest count, ties to the lowest key
          for (int i = 0; i < ENTRIES_DEF; i++)
            if (valid_q[i] && (slot < 0 || count_q[i] < count_q[slot] ||
                (count_q[i] == count_q[slot] && key_q[i] < key_q[slot])))
              slot = i;
          o.evicted     = 1'b1;
          o.evicted_key = key_q[slot];
        end
        valid_q[slot]  = 1'b1;
        key_q[slot]    = key;
        count_q[slot]  = 1;
        o.access_count = 1;
      end
      o.miss_total = misses;
      pending.push_back(o);
    endfunction

    function void check_outcome(logic [TUSER_OUT_W-1:0] user, logic [TDATA_OUT_W-1:0] data);
      lfu_outcome_t got;
      lfu_outcome_t want;
      got.hit          = user[0];
      got.evicted      = user[1];
      got.evicted_key  = data[31:0];
      got.access_count = data[63:32];
      got.miss_total   = data[95:64];
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result hit=%0b ev=%0b ev_key=%h count=%0d misses=%0d",
                   $realtime, got.hit, got.evicted, got.evicted_key, got.access_count,
                   got.miss_total);
        return;
      end
      want = pending.pop_front();
      if (got.hit !== want.hit || got.evicted !== want.evicted ||
          got.evicted_key !== want.evicted_key || got.access_count !== want.access_count ||
          got.miss_total !== want.miss_total) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: result mismatch", $realtime);
          $display("  want hit=%0b ev=%0b ev_key=%h count=%0d misses=%0d", want.hit,
                   want.evicted, want.evicted_key, want.access_count, want.miss_total);
          $display("  got  hit=%0b ev=%0b ev_key=%h count=%0d misses=%0d", got.hit,
                   got.evicted, got.evicted_key, got.access_count, got.miss_total);
        end
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [TDATA_IN_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [TDATA_OUT_W-1:0] m_axis_tdata;
  logic [TUSER_OUT_W-1:0] m_axis_tuser;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CAP_W-1:0]       cfg_data = '0;

  lfu_shadow   shadow = new();
  logic [31:0] key_pool[KEY_POOL];
  // Chance, in percent, that the sender idles / the receiver stalls on a cycle.
  int unsigned gap_pct   = 0;
  int unsigned stall_pct = 0;

  lfu_cache_replacement_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Receive side: random back-pressure; every result transfer is checked
  // against the oldest outstanding prediction.
  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    if (!rst && m_axis_tvalid && m_axis_tready)
      shadow.check_outcome(m_axis_tuser, m_axis_tdata);
  end

  // Idle cycles (tvalid low) go in front of the item, so back-to-back items
  // keep tvalid high with no dip in between.
  task automatic send_request(input logic [31:0] key);
    while ($urandom_range(0, 99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= key;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    shadow.note_request(key);
  endtask

  // Stop sending and let every outstanding result drain, plus settling time.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (shadow.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    shadow.capacity = value;
    cfg_valid <= 1'b0;
  endtask

  // 0: no idling, 1: sender idles, 2: receiver stalls, 3: both, lightly.
  task automatic set_idling(input int mode);
    case (mode)
      1:       begin gap_pct = 83; stall_pct = 0;  end
      2:       begin gap_pct = 0;  stall_pct = 83; end
      3:       begin gap_pct = 28; stall_pct = 28; end
      default: begin gap_pct = 0;  stall_pct = 0;  end
    endcase
  endtask

  // Capacity per random phase: extremes (0, 1, 64, 127) and a spread between.
  function automatic logic [CAP_W-1:0] phase_capacity(input int p);
    case (p)
      0:       return CAP_W'(1);
      1:       return CAP_W'(64);
      2:       return CAP_W'(127);
      3:       return CAP_W'(2);
      4:       return CAP_W'(0);
      5:       return CAP_W'(8);
      6:       return CAP_W'(40);
      7:       return CAP_W'(4);
      8:       return CAP_W'(64);
      9:       return CAP_W'(16);
      10:      return CAP_W'(63);
      default: return CAP_W'(3);
    endcase
  endfunction

  // Mostly keys from a skewed slice of the pool just larger than the store,
  // so hits pile up unevenly and evictions see a spread of counts; some fresh
  // random keys and edge patterns on top.
  function automatic logic [31:0] pick_key(input int unsigned span);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 6) return $urandom;
    if (r < 9) begin
      case ($urandom_range(0, 2))
        0:       return 32'h0000_0000;
        1:       return 32'hFFFF_FFFF;
        default: return 32'h1 << $urandom_range(0, 31);
      endcase
    end
    return key_pool[$urandom_range(0, $urandom_range(0, span - 1))];
  endfunction

  initial begin
    int unsigned span;
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < KEY_POOL; i++) key_pool[i] = $urandom;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: small store, extreme keys, hits, a full store evicting by
    // count and then by key on a tie.
    set_idling(0);
    write_capacity(CAP_W'(3));
    send_request(32'h0000_0000);
    send_request(32'hFFFF_FFFF);
    send_request(32'h0000_0000);
    send_request(32'h0000_0000);
    send_request(32'h8000_0000);
    send_request(32'h0000_0001);
    send_request(32'hFFFF_FFFF);
    send_request(32'h7FFF_FFFF);
    send_request(32'h7FFF_FFFF);
    wait_drained();
    // Capacity zero clamps to one, below the three resident entries: each
    // miss evicts and refills, occupancy stays put.
    write_capacity(CAP_W'(0));
    send_request(32'h1234_5678);
    send_request(32'h1234_5678);
    send_request(32'hFFFF_FFFF);
    send_request(32'hAAAA_AAAA);
    wait_drained();
    // Oversize setting clamps to the full store; free slots fill again.
    write_capacity(CAP_W'(127));
    send_request(32'h0000_0000);
    send_request(32'hA5A5_A5A5);
    send_request(32'h5A5A_5A5A);
    send_request(32'h0000_0000);
    send_request(32'h5555_5555);

    // Random phases, each with its own capacity and idling pattern.
    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      write_capacity(phase_capacity(p));
      set_idling(p % 4);
      repeat (8) key_pool[$urandom_range(2, KEY_POOL - 1)] = $urandom;
      span = shadow.effective_capacity() + 6;
      if (span > KEY_POOL) span = KEY_POOL;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // hold off mid-phase until the pipe is empty
        if (n == PHASE_ITEMS / 2 && p % 3 == 1) wait_drained();
        send_request(pick_key(span));
      end
    end

    wait_drained();
    if (shadow.mismatches == 0 && shadow.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

### filelist.f
hdl/lfu_pkg.sv
hdl/lfu_ctrl.sv
hdl/lfu_datapath.sv
hdl/lfu_cache_replacement_core.sv
dv/lfu_cache_replacement_core_test.sv
